@@ hw/rtl/bbc_pkg.sv @@
// Shared types and constants for the clamped RGBA box blur.
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_WINDOW_DEF = 7;
   localparam int MAX_HEIGHT     = 1024;

   localparam int DIM_W     = 11;
   localparam int ROW_W     = 10;
   localparam int POS_W     = 10;
   localparam int WIN_W     = 3;
   localparam int SUM_W     = 14;
   localparam int AREA_W    = 6;
   localparam int DIVCNT_W  = 4;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
   localparam logic [WIN_W-1:0] WINDOW_WIDTH_RST  = 3'd3;
   localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RST = 3'd3;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH   = 2'd0,
      REG_FRAME_HEIGHT  = 2'd1,
      REG_WINDOW_WIDTH  = 2'd2,
      REG_WINDOW_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUM,
      ST_DRAIN,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic add;
      logic load;
      logic step;
   } lane_ctl_type;

endpackage
`default_nettype wire

@@ hw/rtl/bbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/bbc_lane.sv @@
// One color channel: window sum accumulator and bit-serial divider by the area.
`timescale 1ns / 1ps
`default_nettype none
module bbc_lane (
   input  wire logic                              clock,
   input  wire bbc_pkg::lane_ctl_type             ctl,
   input  wire logic [7:0]                        tap,
   input  wire logic [bbc_pkg::AREA_W-1:0]        area,
   output logic      [7:0]                        mean
);

   logic [bbc_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic [bbc_pkg::AREA_W:0]   rem_ff, rem_in;
   logic [bbc_pkg::AREA_W:0]   rem_sh;

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      rem_sh = {rem_ff[bbc_pkg::AREA_W-1:0], acc_ff[bbc_pkg::SUM_W-1]};
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.add) begin
         acc_in = acc_ff + bbc_pkg::SUM_W'(tap);
      end else if (ctl.load) begin
         rem_in = '0;
      end else if (ctl.step) begin
         // Restoring division: the quotient bits shift in where the dividend leaves.
         if (rem_sh >= {1'b0, area}) begin
            rem_in = rem_sh - {1'b0, area};
            acc_in = {acc_ff[bbc_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            acc_in = {acc_ff[bbc_pkg::SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign mean = acc_ff[7:0];

endmodule
`default_nettype wire

@@ hw/rtl/bbc_merge.sv @@
// Output register that gathers the four lane means and the pixel position.
`timescale 1ns / 1ps
`default_nettype none
module bbc_merge (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire logic [7:0]               red,
   input  wire logic [7:0]               green,
   input  wire logic [7:0]               blue,
   input  wire logic [7:0]               alpha,
   input  wire logic [bbc_pkg::POS_W-1:0] col,
   input  wire logic [bbc_pkg::POS_W-1:0] row,
   input  wire logic                     last,
   output logic                          room,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic [7:0]                    rsp_out_alpha,
   output logic [bbc_pkg::POS_W-1:0]     rsp_out_col,
   output logic [bbc_pkg::POS_W-1:0]     rsp_out_row,
   output logic                          rsp_frame_end
);

   logic valid_ff, valid_in;
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic [bbc_pkg::POS_W-1:0] col_ff, row_ff;
   logic last_ff;

   assign room = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         red_ff   <= red;
         green_ff <= green;
         blue_ff  <= blue;
         alpha_ff <= alpha;
         col_ff   <= col;
         row_ff   <= row;
         last_ff  <= last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_out_alpha = alpha_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_frame_end = last_ff;

endmodule
`default_nettype wire

@@ hw/rtl/rgba_box_blur_clamped.sv @@
// Top level of the clamped RGBA box blur: control, line store and lanes.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_stall  | action and one RGBA pixel
//   rsp     | out       | rsp_valid/rsp_stall  | blurred RGBA pixel, position, frame end
//   csr     | in/out    | APB psel/penable     | one 32-bit register
//
// An item without output passes through the check state back to idle. An item
// with output makes one line store read per window tap, then a 14-step divider
// runs in each of the four channel lanes side by side.
// Reset is synchronous and clears the control state; the line store is not
// cleared. A stalled output beat holds while the next item is taken in.
`timescale 1ns / 1ps
`default_nettype none
module rgba_box_blur_clamped #(
   parameter int MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = bbc_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_action,
   input  wire logic [7:0]                   req_in_red,
   input  wire logic [7:0]                   req_in_green,
   input  wire logic [7:0]                   req_in_blue,
   input  wire logic [7:0]                   req_in_alpha,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [7:0]                        rsp_out_red,
   output logic [7:0]                        rsp_out_green,
   output logic [7:0]                        rsp_out_blue,
   output logic [7:0]                        rsp_out_alpha,
   output logic [bbc_pkg::POS_W-1:0]         rsp_out_col,
   output logic [bbc_pkg::POS_W-1:0]         rsp_out_row,
   output logic                              rsp_frame_end,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [bbc_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [bbc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bbc_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RING  = (MAX_WINDOW | 1) + 1;
   localparam int RW    = $clog2(RING);
   localparam int AW    = RW + CW;
   localparam int DEPTH = RING << CW;
   localparam int XW    = (CW + 1 > bbc_pkg::DIM_W) ? CW + 1 : bbc_pkg::DIM_W;
   localparam logic [3:0]    WIN_CAP   = 4'(MAX_WINDOW | 1);
   localparam logic [RW-1:0] RING_LAST = RW'(RING - 1);
   localparam int DW = bbc_pkg::DIM_W;
   localparam int RWD = bbc_pkg::ROW_W;

   // Configuration registers.
   logic [DW-1:0] frame_width_ff, frame_height_ff;
   logic [bbc_pkg::WIN_W-1:0] window_width_ff, window_height_ff;
   logic cfg_write;
   bbc_pkg::reg_index_type cfg_index;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = bbc_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (cfg_index)
         bbc_pkg::REG_FRAME_WIDTH:   csr_prdata = 32'(frame_width_ff);
         bbc_pkg::REG_FRAME_HEIGHT:  csr_prdata = 32'(frame_height_ff);
         bbc_pkg::REG_WINDOW_WIDTH:  csr_prdata = 32'(window_width_ff);
         bbc_pkg::REG_WINDOW_HEIGHT: csr_prdata = 32'(window_height_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= bbc_pkg::FRAME_WIDTH_RST;
         frame_height_ff  <= bbc_pkg::FRAME_HEIGHT_RST;
         window_width_ff  <= bbc_pkg::WINDOW_WIDTH_RST;
         window_height_ff <= bbc_pkg::WINDOW_HEIGHT_RST;
      end else if (cfg_write) begin
         unique case (cfg_index)
            bbc_pkg::REG_FRAME_WIDTH:   frame_width_ff   <= csr_pwdata[DW-1:0];
            bbc_pkg::REG_FRAME_HEIGHT:  frame_height_ff  <= csr_pwdata[DW-1:0];
            bbc_pkg::REG_WINDOW_WIDTH:  window_width_ff  <= csr_pwdata[bbc_pkg::WIN_W-1:0];
            bbc_pkg::REG_WINDOW_HEIGHT: window_height_ff <= csr_pwdata[bbc_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame and window sizes.
   logic [XW-1:0] fw_x, w_x;
   logic [CW:0]   w_eff, wm1;
   logic [DW-1:0] h_eff, hm1;
   logic [3:0]    ww_o, wh_o;
   logic [bbc_pkg::WIN_W-1:0] ww, wh;
   logic [1:0]    hx, hy;
   logic [bbc_pkg::AREA_W-1:0] area;

   always_comb begin
      fw_x = XW'(frame_width_ff);
      if (fw_x == '0) begin
         w_x = XW'(1);
      end else if (fw_x > XW'(MAX_WIDTH)) begin
         w_x = XW'(MAX_WIDTH);
      end else begin
         w_x = fw_x;
      end
      w_eff = w_x[CW:0];
      wm1   = w_eff - 1'b1;
      if (frame_height_ff == '0) begin
         h_eff = DW'(1);
      end else if (frame_height_ff > DW'(bbc_pkg::MAX_HEIGHT)) begin
         h_eff = DW'(bbc_pkg::MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
      hm1  = h_eff - 1'b1;
      ww_o = {1'b0, window_width_ff | 3'd1};
      wh_o = {1'b0, window_height_ff | 3'd1};
      ww   = (ww_o > WIN_CAP) ? WIN_CAP[2:0] : ww_o[2:0];
      wh   = (wh_o > WIN_CAP) ? WIN_CAP[2:0] : wh_o[2:0];
      hx   = ww[2:1];
      hy   = wh[2:1];
      area = bbc_pkg::AREA_W'(ww) * bbc_pkg::AREA_W'(wh);
   end

   // Control state.
   bbc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  in_col_ff, in_col_in, emit_col_ff, emit_col_in;
   logic [RWD-1:0] in_row_ff, in_row_in, emit_row_ff, emit_row_in;
   logic [RW-1:0]  in_ring_ff, in_ring_in, emit_ring_ff, emit_ring_in;
   logic [RW-1:0]  tap_ring_ff, tap_ring_in;
   logic signed [RWD+1:0] tap_t_ff, tap_t_in;
   logic [bbc_pkg::WIN_W-1:0] cnt_x_ff, cnt_x_in, cnt_y_ff, cnt_y_in;
   logic [bbc_pkg::DIVCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic in_done_ff, in_done_in;
   logic rd_pend_ff;

   logic accept, write_px, ready, room, last_px, load_out;
   logic [DW-1:0] need_r, need_r_c;
   logic [CW:0]   need_c, need_c_c;
   logic [1:0]    back;
   logic [RW+1:0] ring_sum;
   logic signed [CW+1:0] tc;
   logic [CW-1:0] tap_col;
   logic row_adv, x_last, y_last, div_last;
   logic rd_en;
   logic [AW-1:0] rd_addr;
   bbc_pkg::lane_ctl_type lane_ctl;

   assign req_stall = (state_ff != bbc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign write_px  = accept && !req_action && !in_done_ff;
   assign last_px   = (emit_row_ff == hm1[RWD-1:0]) && ({1'b0, emit_col_ff} == wm1);

   always_comb begin
      need_r   = DW'(emit_row_ff) + DW'(hy);
      need_r_c = (need_r > hm1) ? hm1 : need_r;
      need_c   = (CW+1)'(emit_col_ff) + (CW+1)'(hx);
      need_c_c = (need_c > wm1) ? wm1 : need_c;
      ready = in_done_ff || (DW'(in_row_ff) > need_r_c) ||
              ((DW'(in_row_ff) == need_r_c) && ({1'b0, in_col_ff} > need_c_c));
      // Ring slot of the top window row after clamping to row zero.
      back     = (emit_row_ff >= RWD'(hy)) ? hy : emit_row_ff[1:0];
      ring_sum = (RW+2)'(emit_ring_ff) + (RW+2)'(RING) - (RW+2)'(back);
      tc = $signed({2'b00, emit_col_ff}) - $signed((CW+2)'(hx))
           + $signed((CW+2)'(cnt_x_ff));
      if (tc < 0) begin
         tap_col = '0;
      end else if (tc > $signed({1'b0, wm1})) begin
         tap_col = wm1[CW-1:0];
      end else begin
         tap_col = tc[CW-1:0];
      end
      row_adv  = !tap_t_ff[RWD+1] && (tap_t_ff < $signed({1'b0, hm1}));
      x_last   = (cnt_x_ff == ww - 1'b1);
      y_last   = (cnt_y_ff == wh - 1'b1);
      div_last = (div_cnt_ff == bbc_pkg::DIVCNT_W'(bbc_pkg::SUM_W - 1));
      rd_addr  = {tap_ring_ff, tap_col};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbc_pkg::ST_IDLE:  if (accept) state_in = bbc_pkg::ST_CHECK;
         bbc_pkg::ST_CHECK: state_in = ready ? bbc_pkg::ST_SUM : bbc_pkg::ST_IDLE;
         bbc_pkg::ST_SUM:   if (x_last && y_last) state_in = bbc_pkg::ST_DRAIN;
         bbc_pkg::ST_DRAIN: state_in = bbc_pkg::ST_LOAD;
         bbc_pkg::ST_LOAD:  state_in = bbc_pkg::ST_DIV;
         bbc_pkg::ST_DIV:   if (div_last) state_in = bbc_pkg::ST_OUT;
         bbc_pkg::ST_OUT:   if (room) state_in = bbc_pkg::ST_IDLE;
         default:           state_in = bbc_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      lane_ctl = '0;
      rd_en    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         bbc_pkg::ST_CHECK: lane_ctl.clear = 1'b1;
         bbc_pkg::ST_SUM: begin
            rd_en        = 1'b1;
            lane_ctl.add = rd_pend_ff;
         end
         bbc_pkg::ST_DRAIN: lane_ctl.add  = rd_pend_ff;
         bbc_pkg::ST_LOAD:  lane_ctl.load = 1'b1;
         bbc_pkg::ST_DIV:   lane_ctl.step = 1'b1;
         bbc_pkg::ST_OUT:   load_out      = room;
         default: ;
      endcase
   end

   // Positions and counters.
   always_comb begin
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_ring_in   = in_ring_ff;
      in_done_in   = in_done_ff;
      emit_col_in  = emit_col_ff;
      emit_row_in  = emit_row_ff;
      emit_ring_in = emit_ring_ff;
      tap_ring_in  = tap_ring_ff;
      tap_t_in     = tap_t_ff;
      cnt_x_in     = cnt_x_ff;
      cnt_y_in     = cnt_y_ff;
      div_cnt_in   = div_cnt_ff;
      if (write_px) begin
         if ((CW+1)'(in_col_ff) + 1'b1 >= w_eff) begin
            in_col_in  = '0;
            in_ring_in = (in_ring_ff == RING_LAST) ? '0 : in_ring_ff + 1'b1;
            if (DW'(in_row_ff) + 1'b1 >= h_eff) begin
               in_row_in  = '0;
               in_ring_in = '0;
               in_done_in = 1'b1;
            end else begin
               in_row_in = in_row_ff + 1'b1;
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
      if (state_ff == bbc_pkg::ST_CHECK) begin
         cnt_x_in    = '0;
         cnt_y_in    = '0;
         tap_t_in    = $signed({2'b00, emit_row_ff}) - $signed((RWD+2)'(hy));
         tap_ring_in = (ring_sum >= (RW+2)'(RING)) ? RW'(ring_sum - (RW+2)'(RING))
                                                   : RW'(ring_sum);
      end
      if (state_ff == bbc_pkg::ST_SUM) begin
         if (x_last) begin
            cnt_x_in = '0;
            cnt_y_in = cnt_y_ff + 1'b1;
            tap_t_in = tap_t_ff + $signed((RWD+2)'(1));
            if (row_adv) begin
               tap_ring_in = (tap_ring_ff == RING_LAST) ? '0 : tap_ring_ff + 1'b1;
            end
         end else begin
            cnt_x_in = cnt_x_ff + 1'b1;
         end
      end
      if (state_ff == bbc_pkg::ST_LOAD) begin
         div_cnt_in = '0;
      end else if (state_ff == bbc_pkg::ST_DIV) begin
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (load_out) begin
         if (last_px) begin
            // End of frame: both sides start over at the first pixel.
            in_col_in    = '0;
            in_row_in    = '0;
            in_ring_in   = '0;
            in_done_in   = 1'b0;
            emit_col_in  = '0;
            emit_row_in  = '0;
            emit_ring_in = '0;
         end else if ((CW+1)'(emit_col_ff) + 1'b1 >= w_eff) begin
            emit_col_in  = '0;
            emit_row_in  = emit_row_ff + 1'b1;
            emit_ring_in = (emit_ring_ff == RING_LAST) ? '0 : emit_ring_ff + 1'b1;
         end else begin
            emit_col_in = emit_col_ff + 1'b1;
         end
      end
      if (cfg_write) begin
         in_col_in    = '0;
         in_row_in    = '0;
         in_ring_in   = '0;
         in_done_in   = 1'b0;
         emit_col_in  = '0;
         emit_row_in  = '0;
         emit_ring_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbc_pkg::ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_ring_ff   <= '0;
         in_done_ff   <= 1'b0;
         emit_col_ff  <= '0;
         emit_row_ff  <= '0;
         emit_ring_ff <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_ring_ff   <= in_ring_in;
         in_done_ff   <= in_done_in;
         emit_col_ff  <= emit_col_in;
         emit_row_ff  <= emit_row_in;
         emit_ring_ff <= emit_ring_in;
         rd_pend_ff   <= rd_en;
      end
      tap_ring_ff <= tap_ring_in;
      tap_t_ff    <= tap_t_in;
      cnt_x_ff    <= cnt_x_in;
      cnt_y_ff    <= cnt_y_in;
      div_cnt_ff  <= div_cnt_in;
   end

   // Line store: a ring of rows, red in the low byte.
   logic [31:0] rd_data;

   bbc_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (write_px),
      .wr_addr ({in_ring_ff, in_col_ff}),
      .wr_data ({req_in_alpha, req_in_blue, req_in_green, req_in_red}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic [7:0] mean [4];

   for (genvar k = 0; k < 4; k++) begin : g_lane
      bbc_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .tap   (rd_data[8*k +: 8]),
         .area  (area),
         .mean  (mean[k])
      );
   end

   bbc_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (load_out),
      .red           (mean[0]),
      .green         (mean[1]),
      .blue          (mean[2]),
      .alpha         (mean[3]),
      .col           (bbc_pkg::POS_W'(emit_col_ff)),
      .row           (emit_row_ff),
      .last          (last_px),
      .room          (room),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire
